[hdl/mdc_pkg.sv]
// shared types, constants and helpers for the masked density correlation core
`timescale 1ns / 1ps
`default_nettype none
package mdc_pkg;
	localparam int MAX_POINTS_DEF = 65536;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CNT_W          = 17;
	localparam int SAMPLE_W       = 32;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int QUEUE_DEPTH    = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_A        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STDEV_A       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_B        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STDEV_B       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_ZVAR  = 2'd2;

	localparam logic [15:0] CORR_MINUS_ONE = 16'h8000;
	localparam logic [15:0] CORR_MAX       = 16'h7FFF;

	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_OUTLIER,
		KIND_USED
	} kind_t;

	typedef struct packed {
		logic signed [31:0] sample_a;
		logic signed [31:0] sample_b;
		logic               last_point;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] correlation;
		logic [1:0]         status;
		logic [16:0]        used_count;
		logic [16:0]        outlier_count;
	} result_t;

	typedef struct packed {
		logic signed [31:0] mean_a;
		logic [30:0]        stdev_a;
		logic signed [31:0] mean_b;
		logic [30:0]        stdev_b;
		logic [30:0]        outlier_limit;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] za;
		logic [31:0] zb;
		logic        last;
	} work_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction
endpackage
`default_nettype wire

[hdl/mdc_stream_if.sv]
// valid/ready stream channel carrying one payload type
`timescale 1ns / 1ps
`default_nettype none
interface mdc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/mdc_front.sv]
// front end: mask test, outlier test and positive deviations of one sample pair
`timescale 1ns / 1ps
`default_nettype none
module mdc_front (
	input  mdc_pkg::cfg_t    cfg,
	input  mdc_pkg::sample_t sample,
	output mdc_pkg::work_t   work,
	output logic             keep
);
	import mdc_pkg::*;

	logic signed [32:0] da, db;
	logic signed [33:0] da2, db2;
	logic [31:0]        abs_a, abs_b;
	logic               skip, outlier;

	always_comb begin
		da  = {sample.sample_a[31], sample.sample_a} - {cfg.mean_a[31], cfg.mean_a};
		db  = {sample.sample_b[31], sample.sample_b} - {cfg.mean_b[31], cfg.mean_b};
		da2 = {da, 1'b0};
		db2 = {db, 1'b0};
		skip = (da2 < $signed({3'b000, cfg.stdev_a})) && (db2 < $signed({3'b000, cfg.stdev_b}));
		abs_a = sample.sample_a[31] ? (~sample.sample_a + 32'd1) : sample.sample_a;
		abs_b = sample.sample_b[31] ? (~sample.sample_b + 32'd1) : sample.sample_b;
		outlier = (abs_a > {1'b0, cfg.outlier_limit}) || (abs_b > {1'b0, cfg.outlier_limit});

		work.kind = skip ? KIND_SKIP : (outlier ? KIND_OUTLIER : KIND_USED);
		work.za   = (!da[32] && (da != 33'sd0)) ? da[31:0] : 32'd0;
		work.zb   = (!db[32] && (db != 33'sd0)) ? db[31:0] : 32'd0;
		work.last = sample.last_point;
		// skipped pairs only travel on when they close the set
		keep = !skip || sample.last_point;
	end
endmodule
`default_nettype wire

[hdl/mdc_queue.sv]
// short queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
module mdc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mdc_pkg::work_t wdata,
	output logic           full,
	output logic           valid,
	output mdc_pkg::work_t rdata,
	input  logic           pop
);
	import mdc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	work_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (!push && pop) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

[hdl/mdc_back.sv]
// back end: accumulation, normalization, square root, division and result register
`timescale 1ns / 1ps
`default_nettype none
module mdc_back #(
	parameter int MAX_POINTS = mdc_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = mdc_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mdc_pkg::work_t   q_data,
	output logic             q_pop,
	output logic             res_valid,
	input  logic             res_ready,
	output mdc_pkg::result_t res_data
);
	import mdc_pkg::*;

	localparam int DVD_W = 46;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ACC, S_FIN, S_NORM, S_PROD, S_ROOT, S_DIV
	} state_t;

	state_t           state_q;
	work_t            it_q;
	logic [63:0]      paa_q, pbb_q, pab_q;
	logic [63:0]      sum_a_q, sum_b_q, sum_c_q;
	logic [CNT_W-1:0] used_q, rej_q;
	logic [63:0]      na_q, nb_q, nc_q;
	logic [61:0]      x_q, r_q, bit_q;
	logic [DVD_W-1:0] dvd_q;
	logic [30:0]      rem_q;
	logic [5:0]       cnt_q;
	logic             out_valid_q;
	result_t          out_q;

	logic [63:0] prod_aa, prod_bb, prod_ab;
	logic [61:0] prod_x, r_add, r_nx;
	logic        r_ge, norm_big, d_ge;
	logic [31:0] d_try;
	logic [DVD_W-1:0] quot;

	always_comb begin
		prod_aa  = it_q.za * it_q.za;
		prod_bb  = it_q.zb * it_q.zb;
		prod_ab  = it_q.za * it_q.zb;
		prod_x   = na_q[30:0] * nb_q[30:0];
		norm_big = (|na_q[63:31]) || (|nb_q[63:31]) || (|nc_q[63:31]);
		r_add    = r_q + bit_q;
		r_ge     = (x_q >= r_add);
		r_nx     = r_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
		d_try    = {rem_q, dvd_q[DVD_W-1]};
		d_ge     = (d_try >= {1'b0, r_q[30:0]});
		quot     = {dvd_q[DVD_W-2:0], d_ge};
	end

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			it_q        <= '0;
			paa_q       <= '0;
			pbb_q       <= '0;
			pab_q       <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			sum_c_q     <= '0;
			used_q      <= '0;
			rej_q       <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			nc_q        <= '0;
			x_q         <= '0;
			r_q         <= '0;
			bit_q       <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q    <= q_data;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					paa_q   <= prod_aa;
					pbb_q   <= prod_bb;
					pab_q   <= prod_ab;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (it_q.kind == KIND_USED) begin
						if (used_q < CNT_MAX) begin
							used_q <= used_q + CNT_W'(1);
						end
						sum_a_q <= sat_add(sum_a_q, paa_q >> FRAC_BITS);
						sum_b_q <= sat_add(sum_b_q, pbb_q >> FRAC_BITS);
						sum_c_q <= sat_add(sum_c_q, pab_q >> FRAC_BITS);
					end else if (it_q.kind == KIND_OUTLIER) begin
						if (rej_q < CNT_MAX) begin
							rej_q <= rej_q + CNT_W'(1);
						end
					end
					state_q <= it_q.last ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (!out_valid_q) begin
						if (used_q == '0 || sum_a_q == '0 || sum_b_q == '0) begin
							out_q.correlation   <= (used_q == '0) ? CORR_MINUS_ONE : 16'h0000;
							out_q.status        <= (used_q == '0) ? STAT_EMPTY : STAT_ZVAR;
							out_q.used_count    <= used_q;
							out_q.outlier_count <= rej_q;
							out_valid_q         <= 1'b1;
							sum_a_q             <= '0;
							sum_b_q             <= '0;
							sum_c_q             <= '0;
							used_q              <= '0;
							rej_q               <= '0;
							state_q             <= S_IDLE;
						end else begin
							na_q    <= sum_a_q;
							nb_q    <= sum_b_q;
							nc_q    <= sum_c_q;
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (norm_big) begin
						na_q <= na_q >> 1;
						nb_q <= nb_q >> 1;
						nc_q <= nc_q >> 1;
					end else begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					x_q     <= prod_x;
					r_q     <= '0;
					bit_q   <= {2'b01, 60'd0};
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (r_ge) begin
						x_q <= x_q - r_add;
					end
					r_q   <= r_nx;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						if (r_nx == '0) begin
							out_q.correlation   <= 16'h0000;
							out_q.status        <= STAT_ZVAR;
							out_q.used_count    <= used_q;
							out_q.outlier_count <= rej_q;
							out_valid_q         <= 1'b1;
							sum_a_q             <= '0;
							sum_b_q             <= '0;
							sum_c_q             <= '0;
							used_q              <= '0;
							rej_q               <= '0;
							state_q             <= S_IDLE;
						end else begin
							rem_q   <= '0;
							dvd_q   <= {nc_q[30:0], 15'd0};
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= d_ge ? 31'(d_try - {1'b0, r_q[30:0]}) : d_try[30:0];
					dvd_q <= quot;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DVD_W - 1)) begin
						out_q.correlation   <= (|quot[DVD_W-1:15]) ? CORR_MAX : {1'b0, quot[14:0]};
						out_q.status        <= STAT_OK;
						out_q.used_count    <= used_q;
						out_q.outlier_count <= rej_q;
						out_valid_q         <= 1'b1;
						sum_a_q             <= '0;
						sum_b_q             <= '0;
						sum_c_q             <= '0;
						used_q              <= '0;
						rej_q               <= '0;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/masked_density_correlation_core.sv]
// top level of the masked density correlation core
// result: a closing beat is queued and accumulated; for an empty set or a zero sum of squares
//   the result is then registered, otherwise it follows up to 33 normalize shifts, 31 root
//   steps and 46 divide steps; the back end first finishes each pair queued ahead of it
// queueing: beats enter a 4-entry queue; the back end takes a new pair only once done with the last
// reset: arst_n clears sums, counters, queue and result register; registers take defaults
`timescale 1ns / 1ps
`default_nettype none
module masked_density_correlation_core #(
	parameter int MAX_POINTS = mdc_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = mdc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mdc_stream_if.sink                     samples,
	mdc_stream_if.source                   results
);
	import mdc_pkg::*;

	// configuration registers; the user must write them only while the core is idle, the block does not enforce it
	cfg_t    cfg_q;
	work_t   work, q_data;
	logic    keep, q_full, q_valid, q_pop, push;
	result_t res_data;
	logic    res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_a        <= '0;
			cfg_q.stdev_a       <= 31'd65536;
			cfg_q.mean_b        <= '0;
			cfg_q.stdev_b       <= 31'd65536;
			cfg_q.outlier_limit <= 31'h7FFFFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MEAN_A:        cfg_q.mean_a        <= cfg_wdata;
				REG_STDEV_A:       cfg_q.stdev_a       <= cfg_wdata[30:0];
				REG_MEAN_B:        cfg_q.mean_b        <= cfg_wdata;
				REG_STDEV_B:       cfg_q.stdev_b       <= cfg_wdata[30:0];
				REG_OUTLIER_LIMIT: cfg_q.outlier_limit <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	// front end classifies each beat; masked pairs that do not close a set are dropped here
	mdc_front u_front (
		.cfg    (cfg_q),
		.sample (samples.data),
		.work   (work),
		.keep   (keep)
	);

	assign samples.ready = !q_full;
	assign push          = samples.valid && !q_full && keep;

	// decouples the front end, one beat per cycle while the queue is not full, from the multi-cycle back end
	mdc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (work),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_data),
		.pop    (q_pop)
	);

	// back end accumulates and, on the closing pair, works out the correlation
	mdc_back #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (results.ready),
		.res_data  (res_data)
	);

	assign results.valid = res_valid;
	assign results.data  = res_data;
endmodule
`default_nettype wire

[hdl/mdc_checker.sv]
// port-level checker for the result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mdc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             valid,
	input logic             ready,
	input mdc_pkg::result_t data
);
	import mdc_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(data))
		else $error("result beat dropped or changed while stalled");

	// an empty set reports minus one and no used pairs
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data.status == STAT_EMPTY |-> data.correlation == CORR_MINUS_ONE
			&& data.used_count == '0)
		else $error("empty set reported wrongly");

	// zero variance reports zero with some used pairs
	a_zvar: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data.status == STAT_ZVAR |-> data.correlation == 16'h0000
			&& data.used_count != '0)
		else $error("zero variance reported wrongly");

	// a normal result is never negative and has some used pairs
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data.status == STAT_OK |-> !data.correlation[15] && data.used_count != '0)
		else $error("ok result out of range");
endmodule

bind masked_density_correlation_core mdc_checker u_mdc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (results.valid),
	.ready  (results.ready),
	.data   (results.data)
);
`default_nettype wire
